[design/phacc_pkg.sv]
// Shared types and constants for the per-channel hit accumulator.
`timescale 1ns / 1ps

package phacc_pkg;

    localparam int TABLE_SLOTS  = 64;
    localparam int CHANNEL_BITS = 10;

    localparam int CHANNEL_FIELD_W = 10;
    localparam int SLOT_FIELD_W    = 6;
    localparam int COUNT_FIELD_W   = 7;

    localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
    localparam int CH_W  = (CHANNEL_BITS < CHANNEL_FIELD_W) ? CHANNEL_BITS : CHANNEL_FIELD_W;

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_SLOTS);

    localparam logic OP_CLEAR   = 1'b0;
    localparam logic OP_DEPOSIT = 1'b1;

    typedef enum logic [1:0] {
        ST_NEW    = 2'd0,
        ST_MERGED = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic        op;
        logic [9:0]  channel;
        logic [31:0] hit_time;
        logic [23:0] energy;
    } t_in_req;

    typedef struct packed {
        logic [5:0]  slot;
        logic [9:0]  hit_channel;
        logic [31:0] earliest_time;
        logic [31:0] energy_sum;
        logic [1:0]  status;
        logic [6:0]  entry_count;
    } t_out_res;

    typedef struct packed {
        logic [CH_W-1:0] channel;
        logic [31:0]     hit_time;
        logic [31:0]     energy;
    } t_entry;

    typedef struct packed {
        logic        match;
        logic [31:0] min_time;
        logic [31:0] sum;
    } t_merge;

endpackage

[design/per_channel_hit_accumulator.sv]
// Top level of the per-channel hit accumulator: sequencer, scan control and output register.
`timescale 1ns / 1ps

// A request on the input channel is either a clear, which empties the table for a new
// event, or an energy deposit. A clear or a deposit with zero energy does not leave the
// idle state and gives no result. Any other deposit gives exactly one result on the output
// channel: the slot and updated entry, merged or new, or a table full report.
// A deposit scans the stored entries one at a time through the single read port of the
// table; each entry passes through two states, S_READ to present the address and S_CHECK
// to compare the registered read data in the shared merge unit. The scan stops at the
// matching slot; a new channel or a full table is known only after the last stored entry.
// The input is stalled for the whole scan. A finished result waits in the output
// register while the receiver stalls; the next request is taken meanwhile, and its
// result waits until the register frees. Reset empties the table and clears the output
// valid at once; stored entries are never read above the entry count, so they need no
// clearing.
module per_channel_hit_accumulator (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  phacc_pkg::t_in_req  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output phacc_pkg::t_out_res o_out_data
);

    phacc_pkg::t_state r_state, n_state;
    logic [phacc_pkg::CNT_W-1:0] r_count, n_count;
    logic [phacc_pkg::IDX_W-1:0] r_idx, n_idx;
    logic [phacc_pkg::CH_W-1:0]  r_req_ch, n_req_ch;
    logic [31:0]                 r_req_time, n_req_time;
    logic [23:0]                 r_req_energy, n_req_energy;
    phacc_pkg::t_out_res         r_res, n_res;
    phacc_pkg::t_out_res         r_out, n_out;
    logic                        r_out_valid, n_out_valid;

    logic                        wr_en;
    logic [phacc_pkg::IDX_W-1:0] wr_addr;
    phacc_pkg::t_entry           wr_data;
    phacc_pkg::t_entry           rd_data;
    phacc_pkg::t_merge           merge;
    logic                        in_take;
    logic                        out_free;
    logic                        last_entry;
    logic                        full;

    phacc_table u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (r_idx),
        .o_rd_data (rd_data)
    );

    phacc_merge u_merge (
        .i_entry    (rd_data),
        .i_channel  (r_req_ch),
        .i_hit_time (r_req_time),
        .i_energy   (r_req_energy),
        .o_merge    (merge)
    );

    assign o_in_stall  = (r_state != phacc_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= phacc_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_idx        <= n_idx;
        r_req_ch     <= n_req_ch;
        r_req_time   <= n_req_time;
        r_req_energy <= n_req_energy;
        r_res        <= n_res;
        r_out        <= n_out;
    end

    always_comb begin
        in_take    = i_in_valid && (r_state == phacc_pkg::S_IDLE);
        out_free   = !r_out_valid || !i_out_stall;
        last_entry = ((phacc_pkg::CNT_W'(r_idx) + phacc_pkg::CNT_W'(1)) == r_count);
        full       = (r_count == phacc_pkg::FULL_COUNT);

        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_req_ch     = r_req_ch;
        n_req_time   = r_req_time;
        n_req_energy = r_req_energy;
        n_res        = r_res;
        n_out        = r_out;
        n_out_valid  = r_out_valid && i_out_stall;

        wr_en   = 1'b0;
        wr_addr = r_idx;
        wr_data = '{channel: r_req_ch, hit_time: merge.min_time, energy: merge.sum};

        case (r_state)
            phacc_pkg::S_IDLE: begin
                if (in_take) begin
                    n_req_ch     = i_in_data.channel[phacc_pkg::CH_W-1:0];
                    n_req_time   = i_in_data.hit_time;
                    n_req_energy = i_in_data.energy;
                    n_idx        = '0;
                    if (i_in_data.op == phacc_pkg::OP_CLEAR) begin
                        n_count = '0;
                    end else if (i_in_data.energy != 24'd0) begin
                        n_state = (r_count == '0) ? phacc_pkg::S_FINISH : phacc_pkg::S_READ;
                        if (r_count == '0) begin
                            n_res.slot          = '0;
                            n_res.hit_channel   = phacc_pkg::CHANNEL_FIELD_W'(
                                i_in_data.channel[phacc_pkg::CH_W-1:0]);
                            n_res.earliest_time = i_in_data.hit_time;
                            n_res.energy_sum    = {8'd0, i_in_data.energy};
                            n_res.status        = phacc_pkg::ST_NEW;
                            n_res.entry_count   = 7'd1;
                            wr_en   = 1'b1;
                            wr_addr = '0;
                            wr_data = '{channel: i_in_data.channel[phacc_pkg::CH_W-1:0],
                                        hit_time: i_in_data.hit_time,
                                        energy: {8'd0, i_in_data.energy}};
                            n_count = phacc_pkg::CNT_W'(1);
                        end
                    end
                end
            end
            phacc_pkg::S_READ: begin
                n_state = phacc_pkg::S_CHECK;
            end
            phacc_pkg::S_CHECK: begin
                n_res.hit_channel = phacc_pkg::CHANNEL_FIELD_W'(r_req_ch);
                n_res.entry_count = phacc_pkg::COUNT_FIELD_W'(r_count);
                if (merge.match) begin
                    wr_en   = 1'b1;
                    wr_addr = r_idx;
                    n_res.slot          = phacc_pkg::SLOT_FIELD_W'(r_idx);
                    n_res.earliest_time = merge.min_time;
                    n_res.energy_sum    = merge.sum;
                    n_res.status        = phacc_pkg::ST_MERGED;
                    n_state = phacc_pkg::S_FINISH;
                end else if (!last_entry) begin
                    n_idx   = r_idx + phacc_pkg::IDX_W'(1);
                    n_state = phacc_pkg::S_READ;
                end else if (full) begin
                    n_res.slot          = '0;
                    n_res.earliest_time = r_req_time;
                    n_res.energy_sum    = {8'd0, r_req_energy};
                    n_res.status        = phacc_pkg::ST_FULL;
                    n_state = phacc_pkg::S_FINISH;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = r_count[phacc_pkg::IDX_W-1:0];
                    wr_data = '{channel: r_req_ch, hit_time: r_req_time,
                                energy: {8'd0, r_req_energy}};
                    n_count = r_count + phacc_pkg::CNT_W'(1);
                    n_res.slot          = phacc_pkg::SLOT_FIELD_W'(r_count);
                    n_res.earliest_time = r_req_time;
                    n_res.energy_sum    = {8'd0, r_req_energy};
                    n_res.status        = phacc_pkg::ST_NEW;
                    n_res.entry_count   = phacc_pkg::COUNT_FIELD_W'(
                        r_count + phacc_pkg::CNT_W'(1));
                    n_state = phacc_pkg::S_FINISH;
                end
            end
            phacc_pkg::S_FINISH: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = phacc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = phacc_pkg::S_IDLE;
            end
        endcase
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= phacc_pkg::FULL_COUNT)
        else $error("Entry count exceeds the table size.");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == phacc_pkg::S_CHECK) |-> (phacc_pkg::CNT_W'(r_idx) < r_count))
        else $error("Scan index reached past the stored entries.");

    a_full_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == phacc_pkg::S_FINISH && r_res.status == phacc_pkg::ST_FULL)
        |-> (r_count == phacc_pkg::FULL_COUNT))
        else $error("Table full reported while slots remain.");

    a_finish_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == phacc_pkg::S_FINISH && (!r_out_valid || !i_out_stall))
        |=> (r_out_valid && r_state == phacc_pkg::S_IDLE))
        else $error("Finished result was not loaded into the output register.");

endmodule

[design/phacc_table.sv]
// Hit table storage with one write port and one registered read port.
`timescale 1ns / 1ps

module phacc_table (
    input  logic                   i_clk,
    input  logic                   i_wr_en,
    input  logic [phacc_pkg::IDX_W-1:0] i_wr_addr,
    input  phacc_pkg::t_entry      i_wr_data,
    input  logic [phacc_pkg::IDX_W-1:0] i_rd_addr,
    output phacc_pkg::t_entry      o_rd_data
);

    phacc_pkg::t_entry r_mem [phacc_pkg::TABLE_SLOTS];
    phacc_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/phacc_merge.sv]
// Shared compare and merge unit: channel match, earliest time and saturating sum.
`timescale 1ns / 1ps

module phacc_merge (
    input  phacc_pkg::t_entry          i_entry,
    input  logic [phacc_pkg::CH_W-1:0] i_channel,
    input  logic [31:0]                i_hit_time,
    input  logic [23:0]                i_energy,
    output phacc_pkg::t_merge          o_merge
);

    logic [32:0] sum_wide;

    always_comb begin
        sum_wide = {1'b0, i_entry.energy} + {9'd0, i_energy};
        o_merge.match    = (i_entry.channel == i_channel);
        o_merge.sum      = sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0];
        o_merge.min_time = (i_entry.hit_time > i_hit_time) ? i_hit_time : i_entry.hit_time;
    end

endmodule
